### rtl/core/rau_pkg.sv
package rau_pkg;

  // operand width and the double width used for products
  localparam int WIDTH = 32;
  localparam int DW    = 2 * WIDTH;
  localparam int CW    = $clog2(DW);

  // operation codes
  localparam logic [3:0] MODE_NORM  = 4'd0;
  localparam logic [3:0] MODE_ADD   = 4'd1;
  localparam logic [3:0] MODE_SUB   = 4'd2;
  localparam logic [3:0] MODE_NEG   = 4'd3;
  localparam logic [3:0] MODE_MUL   = 4'd4;
  localparam logic [3:0] MODE_DIV   = 4'd5;
  localparam logic [3:0] MODE_RECIP = 4'd6;
  localparam logic [3:0] MODE_ABS   = 4'd7;
  localparam logic [3:0] MODE_EQ    = 4'd8;
  localparam logic [3:0] MODE_GT    = 4'd9;
  localparam logic [3:0] MODE_LT    = 4'd10;

  // status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_ERR = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  // kinds of result written to the output register
  localparam logic [1:0] KIND_VAL = 2'd0;
  localparam logic [1:0] KIND_CMP = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  typedef struct packed {
    logic       latch_in;
    logic       load_a;
    logic       load_b;
    logic       zero_fix;
    logic       gcd_init;
    logic       gcd_step;
    logic       div_init;
    logic       div_step;
    logic       store_a;
    logic       store_b;
    logic       mul;
    logic       op;
    logic       out_load;
    logic [1:0] out_kind;
  } rau_cmd_t;

  typedef struct packed {
    logic mode_bad;
    logic den_zero;
    logic w_zero;
    logic gcd_done;
    logic div_done;
    logic uses_b;
    logic is_cmp;
    logic op_err;
  } rau_stat_t;

endpackage

### rtl/core/rau_in_if.sv
interface rau_in_if;
  logic               valid;
  logic               ready;
  logic [3:0]         mode;
  logic signed [31:0] a_num;
  logic signed [31:0] a_den;
  logic signed [31:0] b_num;
  logic signed [31:0] b_den;

  modport source (output valid, mode, a_num, a_den, b_num, b_den, input ready);
  modport sink   (input valid, mode, a_num, a_den, b_num, b_den, output ready);
endinterface

### rtl/core/rau_out_if.sv
interface rau_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_num;
  logic [30:0]        res_den;
  logic               truth;
  logic [1:0]         status;

  modport source (output valid, res_num, res_den, truth, status, input ready);
  modport sink   (input valid, res_num, res_den, truth, status, output ready);
endinterface

### rtl/core/rau_datapath.sv
module rau_datapath (
  input  logic               clk,
  input  rau_pkg::rau_cmd_t  cmd,
  output rau_pkg::rau_stat_t stat,
  input  logic [3:0]         in_mode,
  input  logic [31:0]        in_a_num,
  input  logic [31:0]        in_a_den,
  input  logic [31:0]        in_b_num,
  input  logic [31:0]        in_b_den,
  output logic signed [31:0] res_num,
  output logic [30:0]        res_den,
  output logic               truth,
  output logic [1:0]         status
);
  import rau_pkg::*;

  localparam logic [DW-1:0] HALF = DW'(1) << (WIDTH - 1);

  // sign and magnitude of the low WIDTH bits
  function automatic logic [WIDTH:0] split(input logic [31:0] v);
    logic [WIDTH-1:0] x;
    logic             n;
    x = v[WIDTH-1:0];
    n = x[WIDTH-1];
    return {n, n ? (~x + 1'b1) : x};
  endfunction

  logic [3:0]       mode;
  logic [31:0]      an_q, ad_q, bn_q, bd_q;
  logic             w_neg;
  logic [DW-1:0]    w_mag, w_den;
  logic             a_neg, b_neg;
  logic [WIDTH-1:0] a_mag, a_den, b_mag, b_den;
  logic [DW-1:0]    gx, gy, dvs;
  logic [CW-1:0]    gk, cnt;
  logic [DW:0]      r1, r2;
  logic [DW-1:0]    q1, q2;
  logic [DW-1:0]    m1, m2, pd, pm;
  logic             truth_q;

  logic [WIDTH:0]   sn, sd;
  logic [DW:0]      t1, t2;
  logic             b1, b2;
  logic             bn_eff, s_neg;
  logic [DW-1:0]    s_mag;
  logic             ovf;
  logic [DW-1:0]    lim;

  // load source: operand a or operand b
  always_comb begin
    sn = cmd.load_b ? split(bn_q) : split(an_q);
    sd = cmd.load_b ? split(bd_q) : split(ad_q);
  end

  // restoring divide steps on both quotients
  always_comb begin
    t1 = {r1[DW-1:0], q1[DW-1]};
    t2 = {r2[DW-1:0], q2[DW-1]};
    b1 = (t1 >= {1'b0, dvs});
    b2 = (t2 >= {1'b0, dvs});
  end

  // signed sum of the cross products
  always_comb begin
    bn_eff = (mode == MODE_SUB || mode == MODE_GT || mode == MODE_LT)
             ? ((b_mag != '0) && !b_neg) : b_neg;
    if (a_neg == bn_eff) begin
      s_mag = m1 + m2;
      s_neg = a_neg;
    end else if (m1 >= m2) begin
      s_mag = m1 - m2;
      s_neg = a_neg;
    end else begin
      s_mag = m2 - m1;
      s_neg = bn_eff;
    end
    if (s_mag == '0) s_neg = 1'b0;
  end

  // range check of the reduced result
  always_comb begin
    lim = w_neg ? HALF : HALF - 1'b1;
    ovf = (w_mag > lim) || (w_den > HALF - 1'b1);
  end

  always_comb begin
    stat.mode_bad = (mode > MODE_LT);
    stat.den_zero = (w_den == '0);
    stat.w_zero   = (w_mag == '0);
    stat.gcd_done = (gx == '0);
    stat.div_done = (cnt == CW'(DW - 1));
    stat.uses_b   = (mode == MODE_ADD || mode == MODE_SUB || mode == MODE_MUL ||
                     mode == MODE_DIV || mode == MODE_EQ || mode == MODE_GT ||
                     mode == MODE_LT);
    stat.is_cmp   = (mode == MODE_EQ || mode == MODE_GT || mode == MODE_LT);
    stat.op_err   = (mode == MODE_DIV && b_mag == '0) ||
                    (mode == MODE_RECIP && a_mag == '0);
  end

  // input item latch
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      mode <= in_mode;
      an_q <= in_a_num;
      ad_q <= in_a_den;
      bn_q <= in_b_num;
      bd_q <= in_b_den;
    end
  end

  // working fraction
  always_ff @(posedge clk) begin
    if (cmd.load_a || cmd.load_b) begin
      w_neg <= (sn[WIDTH] != sd[WIDTH]) && (sn[WIDTH-1:0] != '0);
      w_mag <= DW'(sn[WIDTH-1:0]);
      w_den <= DW'(sd[WIDTH-1:0]);
    end else if (cmd.zero_fix) begin
      w_neg <= 1'b0;
      w_den <= DW'(1);
    end else if (cmd.div_step && stat.div_done) begin
      w_mag <= {q1[DW-2:0], b1};
      w_den <= {q2[DW-2:0], b2};
    end else if (cmd.op) begin
      unique case (mode)
        MODE_ADD, MODE_SUB: begin
          w_neg <= s_neg;
          w_mag <= s_mag;
          w_den <= pd;
        end
        MODE_NEG: begin
          w_neg <= (a_mag != '0) && !a_neg;
          w_mag <= DW'(a_mag);
          w_den <= DW'(a_den);
        end
        MODE_MUL: begin
          w_neg <= (a_neg != b_neg) && (pm != '0);
          w_mag <= pm;
          w_den <= pd;
        end
        MODE_DIV: begin
          w_neg <= (a_neg != b_neg) && (a_mag != '0);
          w_mag <= m1;
          w_den <= m2;
        end
        MODE_RECIP: begin
          w_neg <= a_neg;
          w_mag <= DW'(a_den);
          w_den <= DW'(a_mag);
        end
        MODE_ABS: begin
          w_neg <= 1'b0;
          w_mag <= DW'(a_mag);
          w_den <= DW'(a_den);
        end
        default: begin
          w_neg <= a_neg;
          w_mag <= DW'(a_mag);
          w_den <= DW'(a_den);
        end
      endcase
    end
  end

  // reduced operands
  always_ff @(posedge clk) begin
    if (cmd.store_a) begin
      a_neg <= w_neg;
      a_mag <= w_mag[WIDTH-1:0];
      a_den <= w_den[WIDTH-1:0];
    end
    if (cmd.store_b) begin
      b_neg <= w_neg;
      b_mag <= w_mag[WIDTH-1:0];
      b_den <= w_den[WIDTH-1:0];
    end
  end

  // binary gcd, one step a cycle
  always_ff @(posedge clk) begin
    if (cmd.gcd_init) begin
      gx <= w_mag;
      gy <= w_den;
      gk <= '0;
    end else if (cmd.gcd_step && gx != '0) begin
      if (!gx[0] && !gy[0]) begin
        gx <= gx >> 1;
        gy <= gy >> 1;
        gk <= gk + 1'b1;
      end else if (!gx[0]) begin
        gx <= gx >> 1;
      end else if (!gy[0]) begin
        gy <= gy >> 1;
      end else if (gx >= gy) begin
        gx <= (gx - gy) >> 1;
      end else begin
        gy <= (gy - gx) >> 1;
      end
    end
  end

  // divide numerator and denominator by the gcd
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dvs <= gy << gk;
      r1  <= '0;
      r2  <= '0;
      q1  <= w_mag;
      q2  <= w_den;
      cnt <= '0;
    end else if (cmd.div_step) begin
      r1  <= b1 ? t1 - {1'b0, dvs} : t1;
      r2  <= b2 ? t2 - {1'b0, dvs} : t2;
      q1  <= {q1[DW-2:0], b1};
      q2  <= {q2[DW-2:0], b2};
      cnt <= cnt + 1'b1;
    end
  end

  // cross products
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      m1 <= DW'(a_mag) * DW'(b_den);
      m2 <= DW'(b_mag) * DW'(a_den);
      pd <= DW'(a_den) * DW'(b_den);
      pm <= DW'(a_mag) * DW'(b_mag);
    end
  end

  // comparison outcome
  always_ff @(posedge clk) begin
    if (cmd.op) begin
      unique case (mode)
        MODE_EQ: truth_q <= (a_neg == b_neg) && (a_mag == b_mag) && (a_den == b_den);
        MODE_GT: truth_q <= (s_mag != '0) && !s_neg;
        MODE_LT: truth_q <= (s_mag != '0) && s_neg;
        default: truth_q <= 1'b0;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.out_kind)
        KIND_VAL: begin
          truth <= 1'b0;
          if (ovf) begin
            res_num <= '0;
            res_den <= '0;
            status  <= ST_OVF;
          end else begin
            res_num <= w_neg ? -32'(w_mag) : 32'(w_mag);
            res_den <= 31'(w_den);
            status  <= ST_OK;
          end
        end
        KIND_CMP: begin
          res_num <= '0;
          res_den <= '0;
          truth   <= truth_q;
          status  <= ST_OK;
        end
        default: begin
          res_num <= '0;
          res_den <= '0;
          truth   <= 1'b0;
          status  <= ST_ERR;
        end
      endcase
    end
  end

endmodule

### rtl/core/rau_ctrl.sv
module rau_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  rau_pkg::rau_stat_t stat,
  output rau_pkg::rau_cmd_t  cmd
);
  import rau_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LDA   = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_GCD   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_STORE = 4'd5;
  localparam logic [3:0] S_LDB   = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_OP    = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_R = 2'd2;

  logic [3:0] state, state_next;
  logic [1:0] phase, phase_next;
  logic [1:0] kind, kind_next;
  logic       fire;

  assign in_ready = (state == S_IDLE);
  assign fire     = (state == S_FIN) && (!out_valid || out_ready);

  // sequencing of one item
  always_comb begin
    state_next = state;
    phase_next = phase;
    kind_next  = kind;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_next   = S_LDA;
        end
      end
      S_LDA: begin
        cmd.load_a = 1'b1;
        phase_next = PH_A;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.mode_bad || stat.den_zero) begin
          kind_next  = KIND_ERR;
          state_next = S_FIN;
        end else if (stat.w_zero) begin
          cmd.zero_fix = 1'b1;
          state_next   = S_STORE;
        end else begin
          cmd.gcd_init = 1'b1;
          state_next   = S_GCD;
        end
      end
      S_GCD: begin
        if (stat.gcd_done) begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_done) state_next = S_STORE;
      end
      S_STORE: begin
        unique case (phase)
          PH_A: begin
            cmd.store_a = 1'b1;
            state_next  = stat.uses_b ? S_LDB : S_MUL;
          end
          PH_B: begin
            cmd.store_b = 1'b1;
            state_next  = S_MUL;
          end
          default: begin
            kind_next  = KIND_VAL;
            state_next = S_FIN;
          end
        endcase
      end
      S_LDB: begin
        cmd.load_b = 1'b1;
        phase_next = PH_B;
        state_next = S_CHK;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_OP;
      end
      S_OP: begin
        cmd.op = 1'b1;
        if (stat.is_cmp) begin
          kind_next  = KIND_CMP;
          state_next = S_FIN;
        end else if (stat.op_err) begin
          kind_next  = KIND_ERR;
          state_next = S_FIN;
        end else begin
          phase_next = PH_R;
          state_next = S_CHK;
        end
      end
      S_FIN: begin
        cmd.out_kind = kind;
        if (fire) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_A;
      kind      <= KIND_ERR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      kind  <= kind_next;
      if (fire)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

### rtl/core/rational_arithmetic_unit_core.sv
// Fraction arithmetic unit. Each item on req brings a mode and two fractions
// a and b; one result item leaves on rsp with the reduced numerator and positive
// denominator of a value result, a comparison flag and a status (ok, error for a
// bad mode, a zero denominator or a divide by zero, overflow). Items are handled
// one at a time; a bad mode or a zero denominator on a ends an item right after
// its check. Each of a, b (when the mode uses it) and a value result is reduced
// by a binary gcd that removes at least one bit per cycle and then a restoring
// divider that produces one quotient bit per cycle; zero values skip both. A
// finished result waits in the output register while the next item is accepted
// and worked on; a result still held there stops the next item at its last step.
module rational_arithmetic_unit_core (
  input logic     clk,
  input logic     rst,
  rau_in_if.sink  req,
  rau_out_if.source rsp
);
  import rau_pkg::*;

  rau_cmd_t  cmd;
  rau_stat_t stat;

  rau_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rau_datapath u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .stat     (stat),
    .in_mode  (req.mode),
    .in_a_num (req.a_num),
    .in_a_den (req.a_den),
    .in_b_num (req.b_num),
    .in_b_den (req.b_den),
    .res_num  (rsp.res_num),
    .res_den  (rsp.res_den),
    .truth    (rsp.truth),
    .status   (rsp.status)
  );

endmodule
